FILE: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every edge out of reset
`define KVCP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent in the same cycle
`define KVCP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define KVCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/kvcp_pkg.sv
package kvcp_pkg;

  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INT_W    = 15;
  localparam int unsigned OUT_W    = 40;
  localparam int unsigned NUM_KEYS = 9;

  typedef logic [23:0] key_t;

  localparam key_t KEY_TABLE [NUM_KEYS] = '{
    24'h4D4F44,  // MOD
    24'h535255,  // SRU
    24'h535452,  // STR
    24'h535457,  // STW
    24'h534558,  // SEX
    24'h4B5052,  // KPR
    24'h4B4952,  // KIR
    24'h4B5059,  // KPY
    24'h4B4959   // KIY
  };

  localparam logic [INDEX_W-1:0] IDX_MODE = 4'd0;

  localparam logic [2:0] KEY_LEN      = 3'd3;
  localparam logic [2:0] KEY_TOO_LONG = 3'd4;

  localparam logic [INT_W-1:0] INT_MAX = 15'd32767;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

FILE: src/kvcp_q16_round.sv
module kvcp_q16_round #(
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  logic [kvcp_pkg::INT_W-1:0]          integer_part,
  input  logic [$clog2(kvcp_pkg::pow10(FRACTION_DIGITS))-1:0] fraction,
  input  logic [15:0]                         estimate,
  input  logic                                whole_only,
  input  logic                                negative,
  output logic signed [kvcp_pkg::VALUE_W-1:0] value
);

  localparam longint unsigned POW = kvcp_pkg::pow10(FRACTION_DIGITS);
  localparam int unsigned FW = $clog2(POW);
  localparam int unsigned NW = FW + 17;

  logic [NW-1:0] numer;
  logic [NW-1:0] back;
  logic [NW-1:0] remainder;
  logic [16:0]   corrected;
  logic [15:0]   frac_q16;
  logic [kvcp_pkg::VALUE_W-1:0] magnitude;

  // estimate is at most two short of the rounded quotient
  always_comb begin
    numer     = {1'b0, fraction, 16'd0} + NW'(POW / 2);
    back      = NW'(estimate) * NW'(POW);
    remainder = numer - back;
    corrected = 17'(estimate)
              + 17'(remainder >= NW'(POW))
              + 17'(remainder >= NW'(2 * POW));
    frac_q16  = whole_only ? 16'd0 : corrected[15:0];
    magnitude = {1'b0, integer_part, frac_q16};
    value     = negative ? -$signed(magnitude) : $signed(magnitude);
  end

endmodule

FILE: src/key_value_command_line_parser.sv
// channel   dir  beat contents (lowest bit up)
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata[3:0] setting_index, [35:4] setting_value, [39:36] zero
//
// one byte accepted per cycle while s_axis_tready is high; parser state updates on the accepting edge
// the lf that ends a line loads its result into the round stage
// the result path is a two-entry pipeline (round stage, output register)
// so input stalls only when both entries are full and m_axis is stalled
// rst clears the line state and both pipeline entries

`include "assert_macros.svh"

module key_value_command_line_parser #(
  parameter int unsigned LINE_LIMIT      = 64,
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [kvcp_pkg::OUT_W-1:0]   m_axis_tdata    // setting_index, setting_value
);

  localparam longint unsigned POW = kvcp_pkg::pow10(FRACTION_DIGITS);
  localparam int unsigned FW = $clog2(POW);
  localparam int unsigned PW = FW + 17;
  localparam int unsigned LW = $clog2(LINE_LIMIT);
  localparam int unsigned CW = $clog2(FRACTION_DIGITS + 1);
  localparam logic [16:0] RECIP = 17'((64'd1 << (16 + FW)) / POW);

  localparam logic [1:0] PHASE_SPACE = 2'd0;
  localparam logic [1:0] PHASE_INT   = 2'd1;
  localparam logic [1:0] PHASE_FRAC  = 2'd2;
  localparam logic [1:0] PHASE_DONE  = 2'd3;

  // line state
  logic [LW-1:0]               line_length, line_length_next;
  logic                        last_was_cr, last_was_cr_next;
  kvcp_pkg::key_t              key_bytes, key_bytes_next;
  logic [2:0]                  key_length, key_length_next;
  logic                        colon_seen, colon_seen_next;
  logic                        line_void, line_void_next;
  logic [1:0]                  value_phase, value_phase_next;
  logic                        value_negative, value_negative_next;
  logic [kvcp_pkg::INT_W-1:0]  integer_part, integer_part_next;
  logic [FW-1:0]               fraction_digits, fraction_digits_next;
  logic [CW-1:0]               fraction_count, fraction_count_next;
  logic [PW-1:0]               frac_product;

  // round stage
  logic                        s1_valid;
  logic [kvcp_pkg::INDEX_W-1:0] s1_index;
  logic [kvcp_pkg::INT_W-1:0]  s1_integer;
  logic [FW-1:0]               s1_fraction;
  logic [15:0]                 s1_estimate;
  logic                        s1_whole;
  logic                        s1_negative;
  logic signed [kvcp_pkg::VALUE_W-1:0] s1_value;

  logic        out_advance;
  logic        in_fire;
  logic        emit;
  logic [7:0]  c;
  logic [3:0]  digit_val;
  logic        is_digit;
  logic        is_space;
  logic        is_sign;
  logic        line_full;
  logic        line_end;
  logic        int_byte;
  logic        key_ok;
  logic        key_found;
  logic [kvcp_pkg::INDEX_W-1:0] key_index;
  logic [FW-1:0] digit_weight;
  logic [18:0] int_ext;
  logic [18:0] int_sum;

  assign out_advance   = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign c         = s_axis_tdata;
  assign is_digit  = (c >= kvcp_pkg::CHAR_ZERO) && (c <= kvcp_pkg::CHAR_NINE);
  assign digit_val = 4'(c - kvcp_pkg::CHAR_ZERO);
  assign is_space  = (c == kvcp_pkg::CHAR_SPACE)
                  || ((c >= kvcp_pkg::CHAR_TAB) && (c <= kvcp_pkg::CHAR_CR));
  assign is_sign   = (c == kvcp_pkg::CHAR_PLUS) || (c == kvcp_pkg::CHAR_MINUS);
  assign line_full = (line_length == LW'(LINE_LIMIT - 1));
  assign line_end  = last_was_cr && (c == kvcp_pkg::CHAR_LF);
  assign int_byte  = (value_phase == PHASE_INT)
                  || ((value_phase == PHASE_SPACE) && !is_space && !is_sign);

  // place value of the next fraction digit
  always_comb begin
    digit_weight = '0;
    for (int unsigned i = 0; i < FRACTION_DIGITS; i++) begin
      if (fraction_count == CW'(i)) begin
        digit_weight = FW'(kvcp_pkg::pow10(FRACTION_DIGITS - 1 - i));
      end
    end
  end

  always_comb begin
    int_ext = {4'd0, integer_part};
    int_sum = (int_ext << 3) + (int_ext << 1) + 19'(digit_val);
  end

  // key lookup
  always_comb begin
    key_found = 1'b0;
    key_index = '0;
    for (int i = kvcp_pkg::NUM_KEYS - 1; i >= 0; i--) begin
      if (key_bytes == kvcp_pkg::KEY_TABLE[i]) begin
        key_found = 1'b1;
        key_index = kvcp_pkg::INDEX_W'(i);
      end
    end
  end

  assign key_ok = colon_seen && !line_void && (key_length == kvcp_pkg::KEY_LEN);
  assign emit   = in_fire && !line_full && line_end && key_ok && key_found;

  always_comb begin
    line_length_next     = line_length;
    last_was_cr_next     = last_was_cr;
    key_bytes_next       = key_bytes;
    key_length_next      = key_length;
    colon_seen_next      = colon_seen;
    line_void_next       = line_void;
    value_phase_next     = value_phase;
    value_negative_next  = value_negative;
    integer_part_next    = integer_part;
    fraction_digits_next = fraction_digits;
    fraction_count_next  = fraction_count;

    if (line_full || line_end) begin
      line_length_next     = '0;
      last_was_cr_next     = 1'b0;
      key_bytes_next       = '0;
      key_length_next      = '0;
      colon_seen_next      = 1'b0;
      line_void_next       = 1'b0;
      value_phase_next     = PHASE_SPACE;
      value_negative_next  = 1'b0;
      integer_part_next    = '0;
      fraction_digits_next = '0;
      fraction_count_next  = '0;
    end else begin
      line_length_next = line_length + LW'(1);
      last_was_cr_next = (c == kvcp_pkg::CHAR_CR);
      if (!colon_seen) begin
        if (c == kvcp_pkg::CHAR_COLON) begin
          colon_seen_next = 1'b1;
        end else if (c == kvcp_pkg::CHAR_NUL) begin
          line_void_next = 1'b1;
        end else if (key_length < kvcp_pkg::KEY_LEN) begin
          key_bytes_next  = {key_bytes[15:0], c};
          key_length_next = key_length + 3'd1;
        end else begin
          key_length_next = kvcp_pkg::KEY_TOO_LONG;
        end
      end else if (c == kvcp_pkg::CHAR_NUL) begin
        value_phase_next = PHASE_DONE;
      end else begin
        if ((value_phase == PHASE_SPACE) && is_sign) begin
          value_negative_next = (c == kvcp_pkg::CHAR_MINUS);
          value_phase_next    = PHASE_INT;
        end
        if (int_byte) begin
          if (is_digit) begin
            integer_part_next = (int_sum > 19'(kvcp_pkg::INT_MAX))
                              ? kvcp_pkg::INT_MAX : int_sum[kvcp_pkg::INT_W-1:0];
            value_phase_next  = PHASE_INT;
          end else if (c == kvcp_pkg::CHAR_POINT) begin
            value_phase_next = PHASE_FRAC;
          end else begin
            value_phase_next = PHASE_DONE;
          end
        end
        if (value_phase == PHASE_FRAC) begin
          if (is_digit) begin
            if (fraction_count < CW'(FRACTION_DIGITS)) begin
              fraction_digits_next = fraction_digits + FW'(digit_val * digit_weight);
              fraction_count_next  = fraction_count + CW'(1);
            end
          end else begin
            value_phase_next = PHASE_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      last_was_cr     <= 1'b0;
      key_bytes       <= '0;
      key_length      <= '0;
      colon_seen      <= 1'b0;
      line_void       <= 1'b0;
      value_phase     <= PHASE_SPACE;
      value_negative  <= 1'b0;
      integer_part    <= '0;
      fraction_digits <= '0;
      fraction_count  <= '0;
    end else if (in_fire) begin
      line_length     <= line_length_next;
      last_was_cr     <= last_was_cr_next;
      key_bytes       <= key_bytes_next;
      key_length      <= key_length_next;
      colon_seen      <= colon_seen_next;
      line_void       <= line_void_next;
      value_phase     <= value_phase_next;
      value_negative  <= value_negative_next;
      integer_part    <= integer_part_next;
      fraction_digits <= fraction_digits_next;
      fraction_count  <= fraction_count_next;
    end
  end

  // fraction settles before the cr, so this is ready by the lf
  always_ff @(posedge clk) begin
    frac_product <= PW'(fraction_digits) * PW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= emit || (s1_valid && !out_advance);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_index    <= key_index;
      s1_integer  <= integer_part;
      s1_fraction <= fraction_digits;
      s1_estimate <= frac_product[FW +: 16];
      s1_whole    <= (key_index == kvcp_pkg::IDX_MODE);
      s1_negative <= value_negative;
    end
  end

  kvcp_q16_round #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_round (
    .integer_part (s1_integer),
    .fraction     (s1_fraction),
    .estimate     (s1_estimate),
    .whole_only   (s1_whole),
    .negative     (s1_negative),
    .value        (s1_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_advance) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      m_axis_tdata <= {4'd0, s1_value, s1_index};
    end
  end

  `KVCP_ASSERT_ALWAYS(a_line_bound, line_length <= LW'(LINE_LIMIT - 1), "line length past limit")
  `KVCP_ASSERT_ALWAYS(a_key_len, key_length <= kvcp_pkg::KEY_TOO_LONG, "key length out of range")
  `KVCP_ASSERT_NEXT(a_emit_clears, emit, s1_valid && (line_length == '0) && !colon_seen, "emit did not load round stage or clear line")
  `KVCP_ASSERT_NEXT(a_drop_silent, in_fire && line_full, !s1_valid && (line_length == '0), "overlong line left a result or state")

endmodule
